// ===== sv/ofb_pkg.sv =====
// Shared constants, types and the parity encoder of the odd parity block framer.
package ofb_pkg;

  localparam int FRAME_BYTES = 64;
  localparam int STORE_DEPTH = 64;
  localparam int FRAME_CAP   = (FRAME_BYTES < 1) ? 1 :
                               ((FRAME_BYTES > STORE_DEPTH) ? STORE_DEPTH : FRAME_BYTES);
  localparam int IDX_W       = $clog2(STORE_DEPTH);
  localparam int BANKS       = 2;
  localparam int ADDR_W      = IDX_W + 1;
  localparam int RAM_DEPTH   = BANKS * STORE_DEPTH;
  localparam int CHAR_W      = 7;
  localparam int BYTE_W      = 8;
  localparam int LEN_W       = 7;

  typedef struct packed {
    logic             bank;
    logic [LEN_W-1:0] len;
  } desc_t;

  typedef struct packed {
    logic valid;
    logic bank;
  } rel_t;

  typedef struct packed {
    logic [BYTE_W-1:0] data;
    logic              first;
    logic [LEN_W-1:0]  len;
    logic              last;
  } beat_t;

  function automatic logic [BYTE_W-1:0] parity_encode(input logic [CHAR_W-1:0] ch);
    parity_encode = {~(^ch), ch};
  endfunction

endpackage

// ===== sv/ofb_ram.sv =====
// Generic single write port, single read port RAM with registered read data.
module ofb_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 128
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== sv/ofb_front.sv =====
// Front end: accepts characters, encodes parity, fills a bank and posts finished frames.
module ofb_front (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       in_valid,
  output logic                       in_ready,
  input  logic [ofb_pkg::CHAR_W-1:0] data_char,
  input  logic                       end_of_data,
  output logic                       we,
  output logic [ofb_pkg::ADDR_W-1:0] waddr,
  output logic [ofb_pkg::BYTE_W-1:0] wdata,
  output logic                       push,
  output ofb_pkg::desc_t             push_desc,
  input  logic                       q_full,
  input  ofb_pkg::rel_t              rel
);

  logic [ofb_pkg::LEN_W-1:0] fill_count;
  logic [ofb_pkg::LEN_W-1:0] fill_count_next;
  logic                      bank;
  logic                      bank_next;
  logic [ofb_pkg::BANKS-1:0] busy;
  logic [ofb_pkg::BANKS-1:0] busy_next;
  logic                      accept;
  logic [ofb_pkg::LEN_W-1:0] len;
  logic                      flush;

  assign in_ready = !busy[bank] && !q_full;
  assign accept   = in_valid && in_ready;
  assign len      = fill_count + ofb_pkg::LEN_W'(1);
  assign flush    = end_of_data || (len >= ofb_pkg::LEN_W'(ofb_pkg::FRAME_CAP));

  assign we             = accept;
  assign waddr          = {bank, fill_count[ofb_pkg::IDX_W-1:0]};
  assign wdata          = ofb_pkg::parity_encode(data_char);
  assign push           = accept && flush;
  assign push_desc.bank = bank;
  assign push_desc.len  = len;

  always_comb begin
    fill_count_next = fill_count;
    bank_next       = bank;
    busy_next       = busy;
    if (rel.valid) begin
      busy_next[rel.bank] = 1'b0;
    end
    if (accept) begin
      if (flush) begin
        fill_count_next = '0;
        bank_next       = ~bank;
        busy_next[bank] = 1'b1;
      end else begin
        fill_count_next = len;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      fill_count <= '0;
      bank       <= 1'b0;
      busy       <= '0;
    end else begin
      fill_count <= fill_count_next;
      bank       <= bank_next;
      busy       <= busy_next;
    end
  end

`ifndef SYNTHESIS
  a_push_room: assert property (@(posedge clk) disable iff (rst) push |-> !q_full)
    else $error("frame posted into a full queue");
  a_fill_below_cap: assert property (@(posedge clk) disable iff (rst)
      fill_count < ofb_pkg::LEN_W'(ofb_pkg::FRAME_CAP))
    else $error("open frame reached capacity without flush");
`endif

endmodule

// ===== sv/ofb_queue.sv =====
// Two-entry queue of frame descriptors between front and back.
module ofb_queue (
  input  logic           clk,
  input  logic           rst,
  input  logic           push,
  input  ofb_pkg::desc_t push_desc,
  output logic           full,
  input  logic           pop,
  output logic           nonempty,
  output ofb_pkg::desc_t head
);

  ofb_pkg::desc_t ent [2];
  logic [1:0]     cnt;
  logic [1:0]     cnt_next;
  logic           do_pop;
  logic [1:0]     wr_pos;

  assign full     = cnt == 2'd2;
  assign nonempty = cnt != 2'd0;
  assign head     = ent[0];
  assign do_pop   = pop && nonempty;
  assign wr_pos   = cnt - {1'b0, do_pop};
  assign cnt_next = cnt - {1'b0, do_pop} + {1'b0, push};

  always_ff @(posedge clk) begin
    if (push && !wr_pos[0]) begin
      ent[0] <= push_desc;
    end else if (do_pop) begin
      ent[0] <= ent[1];
    end
    if (push && wr_pos[0]) begin
      ent[1] <= push_desc;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= '0;
    end else begin
      cnt <= cnt_next;
    end
  end

endmodule

// ===== sv/ofb_back.sv =====
// Back end: drains a posted bank into a two-entry output buffer, one byte a cycle while that buffer has room.
module ofb_back (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       q_nonempty,
  input  ofb_pkg::desc_t             q_head,
  output logic                       q_pop,
  output logic                       re,
  output logic [ofb_pkg::ADDR_W-1:0] raddr,
  input  logic [ofb_pkg::BYTE_W-1:0] rdata,
  output ofb_pkg::rel_t              rel,
  output logic                       out_valid,
  input  logic                       out_ready,
  output logic [ofb_pkg::BYTE_W-1:0] data_byte,
  output logic                       first_of_frame,
  output logic [ofb_pkg::LEN_W-1:0]  frame_length,
  output logic                       last_of_frame
);

  typedef enum logic [1:0] {
    S_IDLE = 2'b01,
    S_RUN  = 2'b10
  } state_t;

  state_t                    state;
  state_t                    state_next;
  logic                      bank;
  logic [ofb_pkg::LEN_W-1:0] len;
  logic [ofb_pkg::LEN_W-1:0] k;
  logic [ofb_pkg::LEN_W-1:0] k_next;
  logic                      rd_pend;
  logic                      meta_first;
  logic                      meta_last;
  logic [ofb_pkg::LEN_W-1:0] meta_len;
  ofb_pkg::beat_t            ent [2];
  logic [1:0]                cnt;
  logic [1:0]                cnt_next;
  logic                      pop;
  logic [1:0]                wr_pos;
  logic [1:0]                load;
  logic                      room;
  logic                      issue;
  logic                      is_last;
  ofb_pkg::beat_t            rd_beat;

  assign pop     = (cnt != 2'd0) && out_ready;
  assign load    = cnt + {1'b0, rd_pend} - {1'b0, pop};
  assign room    = load < 2'd2;
  assign issue   = (state == S_RUN) && room;
  assign is_last = k == (len - ofb_pkg::LEN_W'(1));
  assign q_pop   = (state == S_IDLE) && q_nonempty;

  assign re        = issue;
  assign raddr     = {bank, k[ofb_pkg::IDX_W-1:0]};
  assign rel.valid = issue && is_last;
  assign rel.bank  = bank;

  assign rd_beat.data  = rdata;
  assign rd_beat.first = meta_first;
  assign rd_beat.len   = meta_len;
  assign rd_beat.last  = meta_last;

  assign wr_pos   = cnt - {1'b0, pop};
  assign cnt_next = cnt - {1'b0, pop} + {1'b0, rd_pend};

  assign out_valid      = cnt != 2'd0;
  assign data_byte      = ent[0].data;
  assign first_of_frame = ent[0].first;
  assign frame_length   = ent[0].len;
  assign last_of_frame  = ent[0].last;

  always_comb begin
    state_next = state;
    k_next     = k;
    unique case (state)
      S_IDLE: begin
        if (q_nonempty) begin
          state_next = S_RUN;
          k_next     = '0;
        end
      end
      S_RUN: begin
        if (issue) begin
          k_next = k + ofb_pkg::LEN_W'(1);
          if (is_last) begin
            state_next = S_IDLE;
          end
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      bank <= q_head.bank;
      len  <= q_head.len;
    end
    if (issue) begin
      meta_first <= k == '0;
      meta_last  <= is_last;
      meta_len   <= len;
    end
    if (rd_pend && !wr_pos[0]) begin
      ent[0] <= rd_beat;
    end else if (pop) begin
      ent[0] <= ent[1];
    end
    if (rd_pend && wr_pos[0]) begin
      ent[1] <= rd_beat;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= S_IDLE;
      k       <= '0;
      rd_pend <= 1'b0;
      cnt     <= '0;
    end else begin
      state   <= state_next;
      k       <= k_next;
      rd_pend <= issue;
      cnt     <= cnt_next;
    end
  end

`ifndef SYNTHESIS
  a_buf_bound: assert property (@(posedge clk) disable iff (rst) cnt <= 2'd2)
    else $error("output buffer overrun");
  a_pend_room: assert property (@(posedge clk) disable iff (rst)
      rd_pend |-> (cnt != 2'd2 || pop))
    else $error("read data arrives with no buffer room");
  a_issue_in_frame: assert property (@(posedge clk) disable iff (rst)
      issue |-> k < len)
    else $error("read issued past frame end");
`endif

endmodule

// ===== sv/odd_parity_block_framer.sv =====
// Top level of the odd parity block framer: front, descriptor queue, frame RAM and back.
//
//   channel  direction  handshake            beat payload
//   input    in         in_valid, in_ready   data_char, end_of_data
//   output   out        out_valid, out_ready data_byte, first_of_frame, frame_length,
//                                            last_of_frame
//
// One character is taken per cycle while the bank being filled is free; two banks
// of the frame RAM alternate, so the front fills one while the back drains the other.
// The back gives one byte per cycle while the output buffer has room; a flushed frame's
// descriptor is queued, then picked up by the back, whose reads pass the registered RAM.
// Input stalls only when both banks hold frames waiting to drain; output stalls
// hold the two-entry output buffer and the RAM read port.
// Reset clears the fill count, bank flags, queue and output buffer; RAM is not cleared.
module odd_parity_block_framer (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       in_valid,
  output logic                       in_ready,
  input  logic [ofb_pkg::CHAR_W-1:0] data_char,
  input  logic                       end_of_data,
  output logic                       out_valid,
  input  logic                       out_ready,
  output logic [ofb_pkg::BYTE_W-1:0] data_byte,
  output logic                       first_of_frame,
  output logic [ofb_pkg::LEN_W-1:0]  frame_length,
  output logic                       last_of_frame
);

  logic                       we;
  logic [ofb_pkg::ADDR_W-1:0] waddr;
  logic [ofb_pkg::BYTE_W-1:0] wdata;
  logic                       re;
  logic [ofb_pkg::ADDR_W-1:0] raddr;
  logic [ofb_pkg::BYTE_W-1:0] rdata;
  logic                       push;
  ofb_pkg::desc_t             push_desc;
  logic                       q_full;
  logic                       q_pop;
  logic                       q_nonempty;
  ofb_pkg::desc_t             q_head;
  ofb_pkg::rel_t              rel;

  ofb_front u_front (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .data_char   (data_char),
    .end_of_data (end_of_data),
    .we          (we),
    .waddr       (waddr),
    .wdata       (wdata),
    .push        (push),
    .push_desc   (push_desc),
    .q_full      (q_full),
    .rel         (rel)
  );

  ofb_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_desc (push_desc),
    .full      (q_full),
    .pop       (q_pop),
    .nonempty  (q_nonempty),
    .head      (q_head)
  );

  ofb_ram #(
    .WIDTH (ofb_pkg::BYTE_W),
    .DEPTH (ofb_pkg::RAM_DEPTH)
  ) u_ram (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata),
    .re    (re),
    .raddr (raddr),
    .rdata (rdata)
  );

  ofb_back u_back (
    .clk            (clk),
    .rst            (rst),
    .q_nonempty     (q_nonempty),
    .q_head         (q_head),
    .q_pop          (q_pop),
    .re             (re),
    .raddr          (raddr),
    .rdata          (rdata),
    .rel            (rel),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .data_byte      (data_byte),
    .first_of_frame (first_of_frame),
    .frame_length   (frame_length),
    .last_of_frame  (last_of_frame)
  );

endmodule

// ===== tb/sv/ofb_frame_checker.sv =====
// Checker for the odd parity block framer: predicts frames and compares output beats.
`timescale 1ns / 1ps

module ofb_frame_checker (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       in_valid,
  input  logic                       in_ready,
  input  logic [ofb_pkg::CHAR_W-1:0] data_char,
  input  logic                       end_of_data,
  input  logic                       out_valid,
  input  logic                       out_ready,
  input  logic [ofb_pkg::BYTE_W-1:0] data_byte,
  input  logic                       first_of_frame,
  input  logic [ofb_pkg::LEN_W-1:0]  frame_length,
  input  logic                       last_of_frame,
  output int                         fail_count,
  output int                         pending,
  output int                         frames_done,
  output int                         bytes_checked
);

  typedef struct packed {
    logic [ofb_pkg::BYTE_W-1:0] enc;
    logic                       first;
    logic [ofb_pkg::LEN_W-1:0]  len;
    logic                       last;
  } frame_beat_t;

  logic [ofb_pkg::BYTE_W-1:0] open_frame[$];
  frame_beat_t                expected_bytes[$];

  initial begin
    fail_count    = 0;
    pending       = 0;
    frames_done   = 0;
    bytes_checked = 0;
  end

  function automatic logic [ofb_pkg::BYTE_W-1:0] odd_parity_byte(
    input logic [ofb_pkg::CHAR_W-1:0] ch
  );
    int ones;
    ones = 0;
    for (int b = 0; b < ofb_pkg::CHAR_W; b++) ones += ch[b];
    return {((ones % 2) == 0) ? 1'b1 : 1'b0, ch};
  endfunction

  task automatic report(input string msg);
    $display("%0t mismatch: %s", $realtime, msg);
    fail_count++;
  endtask

  task automatic absorb_char(input logic [ofb_pkg::CHAR_W-1:0] ch, input logic eod);
    int          len;
    frame_beat_t beat;
    open_frame.push_back(odd_parity_byte(ch));
    if (eod || open_frame.size() >= ofb_pkg::FRAME_CAP) begin
      len = open_frame.size();
      for (int k = 0; k < len; k++) begin
        beat.enc   = open_frame[k];
        beat.first = (k == 0);
        beat.len   = len[ofb_pkg::LEN_W-1:0];
        beat.last  = (k == len - 1);
        expected_bytes.push_back(beat);
      end
      open_frame.delete();
      frames_done++;
    end
  endtask

  task automatic check_byte();
    frame_beat_t want;
    bytes_checked++;
    if (expected_bytes.size() == 0) begin
      report($sformatf("output beat %02h with no byte expected", data_byte));
    end else begin
      want = expected_bytes.pop_front();
      if (data_byte !== want.enc)
        report($sformatf("data_byte got %02h want %02h", data_byte, want.enc));
      if (first_of_frame !== want.first)
        report($sformatf("first_of_frame got %b want %b", first_of_frame, want.first));
      if (frame_length !== want.len)
        report($sformatf("frame_length got %0d want %0d", frame_length, want.len));
      if (last_of_frame !== want.last)
        report($sformatf("last_of_frame got %b want %b", last_of_frame, want.last));
    end
  endtask

  always @(posedge clk) begin
    if (!rst) begin
      if (out_valid && out_ready) check_byte();
      if (in_valid && in_ready) absorb_char(data_char, end_of_data);
      pending = expected_bytes.size();
    end
  end

endmodule

// ===== tb/sv/odd_parity_block_framer_tb.sv =====
// Testbench top for the odd parity block framer: clock, reset, stimulus and verdict.
`timescale 1ns / 1ps

module odd_parity_block_framer_tb;

  localparam int STALL_LIMIT  = 2000;
  localparam int RANDOM_ITEMS = 210;
  localparam int CALM_AFTER   = 170;

  logic                       clk;
  logic                       rst;
  logic                       in_valid;
  logic                       in_ready;
  logic [ofb_pkg::CHAR_W-1:0] data_char;
  logic                       end_of_data;
  logic                       out_valid;
  logic                       out_ready;
  logic [ofb_pkg::BYTE_W-1:0] data_byte;
  logic                       first_of_frame;
  logic [ofb_pkg::LEN_W-1:0]  frame_length;
  logic                       last_of_frame;

  int fail_count;
  int pending;
  int frames_done;
  int bytes_checked;
  int chars_sent;
  int random_sent;
  int quiet_cycles;
  bit idling;

  odd_parity_block_framer dut (
    .clk            (clk),
    .rst            (rst),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .data_char      (data_char),
    .end_of_data    (end_of_data),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .data_byte      (data_byte),
    .first_of_frame (first_of_frame),
    .frame_length   (frame_length),
    .last_of_frame  (last_of_frame)
  );

  ofb_frame_checker chk (
    .clk            (clk),
    .rst            (rst),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .data_char      (data_char),
    .end_of_data    (end_of_data),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .data_byte      (data_byte),
    .first_of_frame (first_of_frame),
    .frame_length   (frame_length),
    .last_of_frame  (last_of_frame),
    .fail_count     (fail_count),
    .pending        (pending),
    .frames_done    (frames_done),
    .bytes_checked  (bytes_checked)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= STALL_LIMIT) begin
        $display("[odd_parity_block_framer] ERROR");
        $finish;
      end
    end
  end

  // Hold off the output side in random bursts.
  initial begin
    out_ready = 1'b1;
    forever begin
      @(negedge clk);
      if (idling && $urandom_range(0, 5) == 0) begin
        out_ready <= 1'b0;
        repeat ($urandom_range(1, 6)) @(negedge clk);
        out_ready <= 1'b1;
      end
    end
  end

  task automatic send_char(input logic [ofb_pkg::CHAR_W-1:0] ch, input logic eod);
    if (idling && $urandom_range(0, 4) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(negedge clk);
    end
    in_valid    <= 1'b1;
    data_char   <= ch;
    end_of_data <= eod;
    do @(posedge clk); while (!(in_valid && in_ready));
    @(negedge clk);
    chars_sent++;
  endtask

  task automatic send_frame(input int len, input logic eod_last);
    for (int i = 0; i < len; i++) begin
      send_char(7'($urandom_range(0, 127)), (i == len - 1) ? eod_last : 1'b0);
      random_sent++;
    end
  endtask

  initial begin
    int len;
    rst          = 1'b1;
    in_valid     = 1'b0;
    data_char    = '0;
    end_of_data  = 1'b0;
    idling       = 1'b0;
    chars_sent   = 0;
    random_sent  = 0;
    quiet_cycles = 0;
    repeat (10) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Single-byte frames at both extremes, then short frames ending on end of data.
    send_char(7'h00, 1'b1);
    send_char(7'h7F, 1'b1);
    send_char(7'h01, 1'b0);
    send_char(7'h03, 1'b0);
    send_char(7'h55, 1'b0);
    send_char(7'h2A, 1'b0);
    send_char(7'h40, 1'b1);
    send_char(7'h7E, 1'b0);
    send_char(7'h3F, 1'b1);

    idling = 1'b1;
    // Full frame closed by end of data, then one that overflows into the next.
    send_frame(ofb_pkg::FRAME_CAP, 1'b1);
    send_frame(ofb_pkg::FRAME_CAP + 6, 1'b1);
    while (random_sent < RANDOM_ITEMS) begin
      idling = (random_sent < CALM_AFTER) && ($urandom_range(0, 5) != 0);
      if ((random_sent + ofb_pkg::FRAME_CAP <= RANDOM_ITEMS) &&
          ($urandom_range(0, 7) == 0)) begin
        send_frame(ofb_pkg::FRAME_CAP, 1'($urandom_range(0, 1)));
      end else begin
        len = $urandom_range(1, 12);
        send_frame(len, (random_sent + len >= RANDOM_ITEMS) ? 1'b1 : 1'($urandom_range(0, 1)));
      end
    end
    if (random_sent > 0) send_char(7'($urandom_range(0, 127)), 1'b1);
    idling = 1'b0;
    in_valid <= 1'b0;

    while (pending != 0) @(posedge clk);
    repeat (20) @(posedge clk);

    $display("Sent %0d characters forming %0d frames (lengths 1 to %0d, end-of-data and",
             chars_sent, frames_done, ofb_pkg::FRAME_CAP);
    $display("full-buffer flushes, random stalls on both sides); %0d output bytes checked.",
             bytes_checked);
    if (fail_count == 0) begin
      $display("[odd_parity_block_framer] OK");
    end else begin
      $display("[odd_parity_block_framer] ERROR");
    end
    $finish;
  end

endmodule
